@@ rtl/sro_pkg.sv @@
// Shared widths, edge bundle type and outcode helper for the segment/rectangle overlap test.
package sro_pkg;

  localparam int CoordW      = 24;  // endpoint coordinate, signed fixed point
  localparam int RectPosW    = 16;  // rectangle corner, signed pixels
  localparam int RectSizeW   = 15;  // rectangle size, unsigned pixels
  localparam int EdgeW       = RectPosW + 1;           // unscaled edge, holds left + width
  localparam int AxisW       = CoordW + 1;             // normal axis component
  localparam int EdgeProdW   = EdgeW + AxisW;          // edge times axis component
  localparam int CornerW     = EdgeProdW + 1;          // corner projection, unscaled
  localparam int CrossW      = 2 * CoordW;             // endpoint cross products
  localparam int ProjW       = CrossW + 1;             // segment projection
  localparam int FracBitsDef = 8;
  localparam int FracBitsMax = 16;
  localparam int OcW         = EdgeW + FracBitsMax + 1;  // outcode compare width

  // outcode bit positions
  localparam int OcLeftBit  = 0;
  localparam int OcAboveBit = 1;
  localparam int OcRightBit = 2;
  localparam int OcBelowBit = 3;

  typedef struct packed {
    logic signed [EdgeW-1:0] l;
    logic signed [EdgeW-1:0] t;
    logic signed [EdgeW-1:0] r;
    logic signed [EdgeW-1:0] b;
  } edge_t;

  // strict outcode of one endpoint against edges scaled by frac fraction bits
  function automatic logic [3:0] outcode(input logic signed [CoordW-1:0] x,
                                         input logic signed [CoordW-1:0] y,
                                         input edge_t e,
                                         input int frac);
    logic signed [OcW-1:0] xw, yw, lw, tw, rw, bw;
    logic [3:0] c;
    xw = OcW'(x);
    yw = OcW'(y);
    lw = OcW'(e.l) <<< frac;
    tw = OcW'(e.t) <<< frac;
    rw = OcW'(e.r) <<< frac;
    bw = OcW'(e.b) <<< frac;
    c = '0;
    c[OcLeftBit]  = xw < lw;
    c[OcAboveBit] = yw < tw;
    c[OcRightBit] = rw < xw;
    c[OcBelowBit] = bw < yw;
    return c;
  endfunction

endpackage

@@ rtl/sro_side_pipe.sv @@
// Three-stage projection pipeline: which side of the segment's line each rectangle corner lies.
module sro_side_pipe import sro_pkg::*; #(
  parameter int FracBits = FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  edge_t                    edges_i,
  input  logic signed [AxisW-1:0]  ax_i,
  input  logic signed [AxisW-1:0]  ay_i,
  input  logic signed [CoordW-1:0] sx_i,
  input  logic signed [CoordW-1:0] sy_i,
  input  logic signed [CoordW-1:0] ex_i,
  input  logic signed [CoordW-1:0] ey_i,
  output logic                     valid_o,
  output logic [3:0]               above_o,
  output logic [3:0]               below_o
);

  localparam int CmpW = ((CornerW + FracBits > ProjW) ? CornerW + FracBits : ProjW) + 1;

  logic valid_a_q, valid_b_q, valid_c_q;

  // stage A: products
  logic signed [EdgeProdW-1:0] lax_q, rax_q, tay_q, bay_q;
  logic signed [CrossW-1:0]    exsy_q, sxey_q;

  // stage B: corner projections (unscaled) and segment projection
  logic signed [CornerW-1:0] corner_q [4];
  logic signed [ProjW-1:0]   proj_q;

  // stage C: side flags
  logic [3:0] above_d, below_d, above_q, below_q;
  logic signed [CmpW-1:0] corner_s [4];
  logic signed [CmpW-1:0] proj_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lax_q  <= edges_i.l * ax_i;
    rax_q  <= edges_i.r * ax_i;
    tay_q  <= edges_i.t * ay_i;
    bay_q  <= edges_i.b * ay_i;
    exsy_q <= ex_i * sy_i;
    sxey_q <= sx_i * ey_i;
  end

  // both endpoints project to the same value on the normal: ex*sy - sx*ey
  always_ff @(posedge clk_i) begin
    corner_q[0] <= CornerW'(lax_q) + CornerW'(tay_q);
    corner_q[1] <= CornerW'(rax_q) + CornerW'(tay_q);
    corner_q[2] <= CornerW'(lax_q) + CornerW'(bay_q);
    corner_q[3] <= CornerW'(rax_q) + CornerW'(bay_q);
    proj_q      <= ProjW'(exsy_q) - ProjW'(sxey_q);
  end

  always_comb begin
    proj_s = CmpW'(proj_q);
    for (int i = 0; i < 4; i++) begin
      corner_s[i] = CmpW'(corner_q[i]) <<< FracBits;
      above_d[i]  = corner_s[i] > proj_s;
      below_d[i]  = corner_s[i] < proj_s;
    end
  end

  always_ff @(posedge clk_i) begin
    above_q <= above_d;
    below_q <= below_d;
  end

  assign valid_o = valid_c_q;
  assign above_o = above_q;
  assign below_o = below_q;

endmodule

@@ rtl/segment_rect_overlap_test.sv @@
// Top level: segment versus axis-aligned rectangle overlap, one query per clock.
//
// Usage: drive the segment endpoints (signed fixed point, FracBits fraction
// bits) and the rectangle (signed left/top, unsigned width/height in pixels)
// together with start_i. A beat is taken at every edge where start_i is high
// and busy_o is low; busy_o is always low, so a new query may enter in every
// cycle.
// The answer is on overlaps_o with valid_o high for exactly one cycle. There
// are five register stages, the first loading at the accepting edge (stage 1
// edges and axis, stage 2 products, stage 3 projection sums, stage 4 corner
// side compares, stage 5 decision); the result beat leaves stage 5. Throughput
// is one query per cycle, set by the fully pipelined multipliers and compares.
// Results leave in the order queries entered.
// The receiver cannot hold results off; the pipeline never stalls.
// Reset (rst_ni low, asynchronous) clears all valid bits, dropping any
// queries in flight; no result is produced for them.
// overlaps_o is 1 when the segment touches or crosses the rectangle,
// boundaries included.
module segment_rect_overlap_test import sro_pkg::*; #(
  parameter int FracBits = FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [CoordW-1:0]    start_x_i,
  input  logic signed [CoordW-1:0]    start_y_i,
  input  logic signed [CoordW-1:0]    end_x_i,
  input  logic signed [CoordW-1:0]    end_y_i,
  input  logic signed [RectPosW-1:0]  rect_left_i,
  input  logic signed [RectPosW-1:0]  rect_top_i,
  input  logic        [RectSizeW-1:0] rect_width_i,
  input  logic        [RectSizeW-1:0] rect_height_i,
  output logic                        valid_o,
  output logic                        overlaps_o
);

  logic accept;

  // stage 1
  logic                     s1_valid_q;
  edge_t                    edges_d, edges_q;
  logic signed [AxisW-1:0]  ax_q, ay_q;
  logic signed [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;

  // early decision path
  logic [3:0] oc0, oc1;
  logic       hit_d, miss_d;
  logic       hit2_q, miss2_q, hit3_q, miss3_q, hit4_q, miss4_q;

  // side pipe
  logic       side_valid;
  logic [3:0] above, below;

  logic valid_q, overlaps_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    edges_d.l = EdgeW'(rect_left_i);
    edges_d.t = EdgeW'(rect_top_i);
    edges_d.r = EdgeW'(rect_left_i) + EdgeW'(rect_width_i);
    edges_d.b = EdgeW'(rect_top_i) + EdgeW'(rect_height_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    edges_q <= edges_d;
    ax_q    <= AxisW'(start_y_i) - AxisW'(end_y_i);
    ay_q    <= AxisW'(end_x_i) - AxisW'(start_x_i);
    sx_q    <= start_x_i;
    sy_q    <= start_y_i;
    ex_q    <= end_x_i;
    ey_q    <= end_y_i;
  end

  // x and y axes can only separate when the outcodes share a bit,
  // so only the normal axis is left for the pipe
  always_comb begin
    oc0    = outcode(sx_q, sy_q, edges_q, FracBits);
    oc1    = outcode(ex_q, ey_q, edges_q, FracBits);
    hit_d  = (oc0 == 4'd0) || (oc1 == 4'd0);
    miss_d = !hit_d && ((oc0 & oc1) != 4'd0);
  end

  always_ff @(posedge clk_i) begin
    hit2_q  <= hit_d;
    miss2_q <= miss_d;
    hit3_q  <= hit2_q;
    miss3_q <= miss2_q;
    hit4_q  <= hit3_q;
    miss4_q <= miss3_q;
  end

  sro_side_pipe #(
    .FracBits(FracBits)
  ) u_side_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .edges_i (edges_q),
    .ax_i    (ax_q),
    .ay_i    (ay_q),
    .sx_i    (sx_q),
    .sy_i    (sy_q),
    .ex_i    (ex_q),
    .ey_i    (ey_q),
    .valid_o (side_valid),
    .above_o (above),
    .below_o (below)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= side_valid;
    end
  end

  // all four corners strictly on one side of the line: separated
  always_ff @(posedge clk_i) begin
    overlaps_q <= hit4_q || (!miss4_q && !((&above) || (&below)));
  end

  assign valid_o    = valid_q;
  assign overlaps_o = overlaps_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 valid_o)
    else $error("result beat missing five cycles after accept");

  a_early_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && hit_d) |-> ##4 (valid_o && overlaps_o))
    else $error("endpoint inside rectangle not reported as overlap");

  a_early_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && miss_d) |-> ##4 (valid_o && !overlaps_o))
    else $error("shared outcode bit not reported as miss");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(s1_valid_q, 4))
    else $error("result beat without matching query");

endmodule

@@ sim/segment_rect_overlap_test_tb.sv @@
// Self-checking testbench for the segment versus rectangle overlap block.
`timescale 1ns / 1ps

module segment_rect_overlap_test_tb;
  import sro_pkg::*;

  localparam int FracBits = FracBitsDef;
  localparam int CycleLimit = 200000;
  localparam int RandomQueries = 1630;
  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [RectPosW-1:0] PosMax = {1'b0, {(RectPosW-1){1'b1}}};
  localparam logic signed [RectPosW-1:0] PosMin = {1'b1, {(RectPosW-1){1'b0}}};
  localparam logic [RectSizeW-1:0] SizeMax = '1;

  typedef struct {
    logic signed [CoordW-1:0]   start_x;
    logic signed [CoordW-1:0]   start_y;
    logic signed [CoordW-1:0]   end_x;
    logic signed [CoordW-1:0]   end_y;
    logic signed [RectPosW-1:0] rect_left;
    logic signed [RectPosW-1:0] rect_top;
    logic [RectSizeW-1:0]       rect_width;
    logic [RectSizeW-1:0]       rect_height;
  } query_t;

  class overlap_scoreboard;
    bit expected_hits[$];
    int errors;

    function logic [3:0] region_code(longint x, longint y, longint l, longint t,
                                     longint r, longint b);
      logic [3:0] c;
      c = '0;
      c[OcLeftBit]  = x < l;
      c[OcAboveBit] = y < t;
      c[OcRightBit] = r < x;
      c[OcBelowBit] = b < y;
      return c;
    endfunction

    // trivial accept/reject on outcodes, then separating axes x, y and segment normal
    function bit predict_overlap(query_t q);
      longint scale, sx, sy, ex, ey, l, t, r, b, p, rlo, rhi, slo, shi;
      longint cx[4], cy[4], ax[3], ay[3];
      logic [3:0] c0, c1;
      bit hit;
      scale = longint'(1) << FracBits;
      sx = longint'(q.start_x);
      sy = longint'(q.start_y);
      ex = longint'(q.end_x);
      ey = longint'(q.end_y);
      l = longint'(q.rect_left) * scale;
      t = longint'(q.rect_top) * scale;
      r = (longint'(q.rect_left) + longint'(q.rect_width)) * scale;
      b = (longint'(q.rect_top) + longint'(q.rect_height)) * scale;
      c0 = region_code(sx, sy, l, t, r, b);
      c1 = region_code(ex, ey, l, t, r, b);
      hit = 1'b1;
      if (c0 != 4'd0 && c1 != 4'd0) begin
        if ((c0 & c1) != 4'd0) begin
          hit = 1'b0;
        end else begin
          cx = '{l, r, l, r};
          cy = '{t, t, b, b};
          ax = '{1, 0, sy - ey};
          ay = '{0, 1, ex - sx};
          for (int k = 0; k < 3; k++) begin
            rlo = cx[0] * ax[k] + cy[0] * ay[k];
            rhi = rlo;
            for (int i = 1; i < 4; i++) begin
              p = cx[i] * ax[k] + cy[i] * ay[k];
              if (p < rlo) rlo = p;
              if (p > rhi) rhi = p;
            end
            slo = sx * ax[k] + sy * ay[k];
            shi = slo;
            p = ex * ax[k] + ey * ay[k];
            if (p < slo) slo = p;
            if (p > shi) shi = p;
            if (shi < rlo || rhi < slo) hit = 1'b0;
          end
        end
      end
      return hit;
    endfunction

    function void note_query(query_t q);
      expected_hits.push_back(predict_overlap(q));
    endfunction

    function void check_answer(logic got);
      bit want;
      if (expected_hits.size() == 0) begin
        $error("overlaps: no result expected, got %0b", got);
        errors++;
      end else begin
        want = expected_hits.pop_front();
        if (got !== want) begin
          $error("overlaps: expected %0b, got %0b", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic signed [CoordW-1:0]    start_x_i;
  logic signed [CoordW-1:0]    start_y_i;
  logic signed [CoordW-1:0]    end_x_i;
  logic signed [CoordW-1:0]    end_y_i;
  logic signed [RectPosW-1:0]  rect_left_i;
  logic signed [RectPosW-1:0]  rect_top_i;
  logic        [RectSizeW-1:0] rect_width_i;
  logic        [RectSizeW-1:0] rect_height_i;
  logic                        valid_o;
  logic                        overlaps_o;

  overlap_scoreboard sb;
  int cycle_count = 0;

  segment_rect_overlap_test #(.FracBits(FracBits)) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .start_x_i(start_x_i),
    .start_y_i(start_y_i),
    .end_x_i(end_x_i),
    .end_y_i(end_y_i),
    .rect_left_i(rect_left_i),
    .rect_top_i(rect_top_i),
    .rect_width_i(rect_width_i),
    .rect_height_i(rect_height_i),
    .valid_o(valid_o),
    .overlaps_o(overlaps_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("segment_rect_overlap_test test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    query_t seen;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        seen.start_x = start_x_i;
        seen.start_y = start_y_i;
        seen.end_x = end_x_i;
        seen.end_y = end_y_i;
        seen.rect_left = rect_left_i;
        seen.rect_top = rect_top_i;
        seen.rect_width = rect_width_i;
        seen.rect_height = rect_height_i;
        sb.note_query(seen);
      end
      if (valid_o) sb.check_answer(overlaps_o);
    end
  end

  // whole pixels to Q16.8
  function automatic logic signed [CoordW-1:0] fx(int pix);
    return CoordW'(pix * (1 << FracBits));
  endfunction

  function automatic query_t mk(logic signed [CoordW-1:0] sx, logic signed [CoordW-1:0] sy,
                                logic signed [CoordW-1:0] ex, logic signed [CoordW-1:0] ey,
                                logic signed [RectPosW-1:0] l, logic signed [RectPosW-1:0] t,
                                logic [RectSizeW-1:0] w, logic [RectSizeW-1:0] h);
    query_t q;
    q.start_x = sx;
    q.start_y = sy;
    q.end_x = ex;
    q.end_y = ey;
    q.rect_left = l;
    q.rect_top = t;
    q.rect_width = w;
    q.rect_height = h;
    return q;
  endfunction

  function automatic query_t rand_any();
    return mk(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
              RectPosW'($urandom), RectPosW'($urandom),
              RectSizeW'($urandom), RectSizeW'($urandom));
  endfunction

  // coordinate within m pixels of [lo, lo+span]; snapped ones sit on whole pixels
  function automatic logic signed [CoordW-1:0] near_coord(logic signed [RectPosW-1:0] lo,
                                                          logic [RectSizeW-1:0] span,
                                                          int m, bit snap);
    longint v;
    v = (longint'(lo) + longint'($urandom_range(0, int'(span) + 2 * m)) - m) << FracBits;
    if (!snap) v += longint'($urandom_range(0, (1 << FracBits) - 1));
    return CoordW'(v);
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int pick, m;
    bit snap;
    q = rand_any();
    pick = $urandom_range(99);
    if (pick < 15) return q;
    snap = pick < 40;
    m = snap ? 3 : 24;
    if ($urandom_range(15) != 0) q.rect_width = RectSizeW'($urandom_range(0, 40));
    if ($urandom_range(15) != 0) q.rect_height = RectSizeW'($urandom_range(0, 40));
    q.start_x = near_coord(q.rect_left, q.rect_width, m, snap);
    q.start_y = near_coord(q.rect_top, q.rect_height, m, snap);
    q.end_x = near_coord(q.rect_left, q.rect_width, m, snap);
    q.end_y = near_coord(q.rect_top, q.rect_height, m, snap);
    if ($urandom_range(9) == 0) begin
      q.end_x = q.start_x;
      q.end_y = q.start_y;
    end
    return q;
  endfunction

  task automatic put_fields(input query_t q);
    start_x_i <= q.start_x;
    start_y_i <= q.start_y;
    end_x_i <= q.end_x;
    end_y_i <= q.end_y;
    rect_left_i <= q.rect_left;
    rect_top_i <= q.rect_top;
    rect_width_i <= q.rect_width;
    rect_height_i <= q.rect_height;
  endtask

  // idle cycles carry junk on the fields with start low
  task automatic issue_query(input query_t q, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 26) begin
        put_fields(rand_any());
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    put_fields(q);
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    query_t directed[$];
    sb = new();
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    put_fields(mk(0, 0, 0, 0, 0, 0, 0, 0));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // rectangle at origin, 10 x 10 pixels
    directed.push_back(mk(fx(2), fx(3), fx(7), fx(8), 0, 0, 10, 10));
    directed.push_back(mk(fx(0), fx(5), fx(-20), fx(5), 0, 0, 10, 10));
    directed.push_back(mk(fx(-5), fx(1), fx(-3), fx(9), 0, 0, 10, 10));
    directed.push_back(mk(fx(1), fx(-5), fx(9), fx(-1), 0, 0, 10, 10));
    directed.push_back(mk(fx(12), fx(12), fx(20), fx(15), 0, 0, 10, 10));
    directed.push_back(mk(fx(-5), fx(5), fx(15), fx(5), 0, 0, 10, 10));
    directed.push_back(mk(fx(5), fx(-5), fx(5), fx(15), 0, 0, 10, 10));
    // diagonal past the corner: miss, exact touch, miss by one LSB
    directed.push_back(mk(fx(-5), fx(4), fx(4), fx(-5), 0, 0, 10, 10));
    directed.push_back(mk(fx(-5), fx(5), fx(5), fx(-5), 0, 0, 10, 10));
    directed.push_back(mk(fx(-5), CoordW'(fx(5) - 1), fx(5), CoordW'(fx(-5) - 1),
                          0, 0, 10, 10));
    // zero-size rectangle
    directed.push_back(mk(fx(0), fx(0), fx(6), fx(6), 3, 3, 0, 0));
    directed.push_back(mk(fx(0), fx(0), fx(6), fx(7), 3, 3, 0, 0));
    // point segments
    directed.push_back(mk(fx(4), fx(4), fx(4), fx(4), 0, 0, 10, 10));
    directed.push_back(mk(fx(-1), fx(4), fx(-1), fx(4), 0, 0, 10, 10));
    directed.push_back(mk(fx(3), fx(3), fx(3), fx(3), 3, 3, 0, 0));
    // field extremes
    directed.push_back(mk(CoordMax, CoordMax, CoordMax, CoordMax, PosMax, PosMax,
                          SizeMax, SizeMax));
    directed.push_back(mk(CoordMin, CoordMin, CoordMin, CoordMin, PosMin, PosMin, 0, 0));
    directed.push_back(mk(CoordMin, CoordMin, CoordMin, CoordMin, PosMax, PosMax,
                          SizeMax, SizeMax));
    directed.push_back(mk(CoordMax, CoordMax, CoordMax, CoordMax, PosMin, PosMin,
                          SizeMax, SizeMax));
    directed.push_back(mk(CoordMin, CoordMin, CoordMax, CoordMax, PosMin, PosMin,
                          SizeMax, SizeMax));
    directed.push_back(mk(CoordMax, CoordMin, CoordMin, CoordMax, 100, 100, 10, 10));
    directed.push_back(mk(CoordMax, CoordMin, CoordMin, CoordMax, -5, -5, 10, 10));
    directed.push_back(mk(CoordMin, CoordMax, CoordMax, CoordMin, PosMin, PosMax, 0, 0));

    foreach (directed[i]) issue_query(directed[i], 1'b1);
    for (int n = 0; n < RandomQueries; n++) begin
      issue_query(rand_query(), !(n >= 700 && n < 1000));
    end
    start_i <= 1'b0;

    while (sb.expected_hits.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("segment_rect_overlap_test test passed");
    end else begin
      $display("segment_rect_overlap_test test failed");
    end
    $finish;
  end

endmodule
